// ===== rtl/pip_pkg.sv =====
`default_nettype none
package pip_pkg;
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_POLYGONS = 8;
	localparam int COORD_W = 32;
	localparam int REGION_W = 4;
	localparam int CFG_W = 4;
	// wide enough for the largest polygon index the parameter range allows
	localparam int POLY_IDX_W = 6;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TEST = 1'b1;

	// one beat of the edge walk
	typedef struct packed {
		logic edge_v;
		logic prime;
		logic last;
		logic done;
		logic [POLY_IDX_W-1:0] poly;
	} pip_tag_t;

	// edge terms after the difference cell
	typedef struct packed {
		pip_tag_t tag;
		logic straddle;
		logic sign_ad;
		logic sign_bc;
		logic [COORD_W-1:0] mag_a;
		logic [COORD_W-1:0] mag_d;
		logic [COORD_W-1:0] mag_b;
		logic [COORD_W-1:0] mag_c;
	} pip_diff_t;

	// edge products after the multiply cell
	typedef struct packed {
		pip_tag_t tag;
		logic straddle;
		logic sign_ad;
		logic sign_bc;
		logic [2*COORD_W-1:0] prod_ad;
		logic [2*COORD_W-1:0] prod_bc;
	} pip_prod_t;
endpackage
`default_nettype wire

// ===== rtl/pip_edge_prep.sv =====
`default_nettype none
module pip_edge_prep
	import pip_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pip_tag_t tag_s1,
	input  wire logic [COORD_W-1:0] vx_s1,
	input  wire logic [COORD_W-1:0] vy_s1,
	input  wire logic [COORD_W-1:0] tx,
	input  wire logic [COORD_W-1:0] ty,
	output pip_diff_t diff_s2
);
	logic [COORD_W-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_W:0] a, b, c, d, c_fix, d_fix;
	logic [COORD_W:0] ma, mb, mc, md;
	logic above_i, above_j;
	pip_diff_t diff_nxt;

	always_comb begin
		a = $signed({tx[COORD_W-1], tx}) - $signed({vx_s1[COORD_W-1], vx_s1});
		b = $signed({prev_x_q[COORD_W-1], prev_x_q}) - $signed({vx_s1[COORD_W-1], vx_s1});
		c = $signed({ty[COORD_W-1], ty}) - $signed({vy_s1[COORD_W-1], vy_s1});
		d = $signed({prev_y_q[COORD_W-1], prev_y_q}) - $signed({vy_s1[COORD_W-1], vy_s1});
		// flip both so that d is not negative
		c_fix = d[COORD_W] ? -c : c;
		d_fix = d[COORD_W] ? -d : d;
		ma = a[COORD_W] ? -a : a;
		mb = b[COORD_W] ? -b : b;
		mc = c_fix[COORD_W] ? -c_fix : c_fix;
		md = d_fix[COORD_W] ? -d_fix : d_fix;
		above_i = $signed(vy_s1) > $signed(ty);
		above_j = $signed(prev_y_q) > $signed(ty);
		diff_nxt.tag = tag_s1;
		diff_nxt.straddle = above_i != above_j;
		diff_nxt.sign_ad = a[COORD_W];
		diff_nxt.sign_bc = b[COORD_W] ^ c_fix[COORD_W];
		diff_nxt.mag_a = ma[COORD_W-1:0];
		diff_nxt.mag_b = mb[COORD_W-1:0];
		diff_nxt.mag_c = mc[COORD_W-1:0];
		diff_nxt.mag_d = md[COORD_W-1:0];
	end

	// hold the previous vertex: it is the far end of the next edge
	always_ff @(posedge clk) begin
		if (tag_s1.prime || tag_s1.edge_v) begin
			prev_x_q <= vx_s1;
			prev_y_q <= vy_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_s2 <= '0;
		end else begin
			diff_s2 <= diff_nxt;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pip_edge_mul.sv =====
`default_nettype none
module pip_edge_mul
	import pip_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pip_diff_t diff_s2,
	output pip_prod_t prod_s3
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s3 <= '0;
		end else begin
			prod_s3.tag <= diff_s2.tag;
			prod_s3.straddle <= diff_s2.straddle;
			prod_s3.sign_ad <= diff_s2.sign_ad;
			prod_s3.sign_bc <= diff_s2.sign_bc;
			prod_s3.prod_ad <= {{COORD_W{1'b0}}, diff_s2.mag_a} * {{COORD_W{1'b0}}, diff_s2.mag_d};
			prod_s3.prod_bc <= {{COORD_W{1'b0}}, diff_s2.mag_b} * {{COORD_W{1'b0}}, diff_s2.mag_c};
		end
	end
endmodule
`default_nettype wire

// ===== rtl/pip_parity.sv =====
`default_nettype none
module pip_parity
	import pip_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pip_prod_t prod_s3,
	output logic res_valid,
	output logic [REGION_W-1:0] res_region
);
	logic parity_q;
	logic [REGION_W-1:0] region_q;
	logic neg_ad, neg_bc, less, par_nxt;

	always_comb begin
		neg_ad = prod_s3.sign_ad && (prod_s3.prod_ad != '0);
		neg_bc = prod_s3.sign_bc && (prod_s3.prod_bc != '0);
		if (neg_ad != neg_bc) begin
			less = neg_ad;
		end else if (neg_ad) begin
			less = prod_s3.prod_bc < prod_s3.prod_ad;
		end else begin
			less = prod_s3.prod_ad < prod_s3.prod_bc;
		end
		par_nxt = parity_q ^ (prod_s3.straddle && less);
	end

	assign res_valid = prod_s3.tag.done;
	assign res_region = region_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			region_q <= '0;
		end else begin
			if (prod_s3.tag.edge_v) begin
				if (prod_s3.tag.last) begin
					parity_q <= 1'b0;
					if (par_nxt) begin
						region_q <= REGION_W'(prod_s3.tag.poly + POLY_IDX_W'(1));
					end
				end else begin
					parity_q <= par_nxt;
				end
			end
			// drop the accumulated region once it is handed out
			if (prod_s3.tag.done) begin
				region_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/point_in_polygon_classifier_core.sv =====
// Point-in-polygon classifier, even-odd crossing test on signed Q16.16 points.
// Input channel (in_valid / in_stall): operation 0 stores one vertex of one
// polygon, and last_vertex sets that polygon's vertex count; operation 1 tests
// the point coord_x, coord_y and yields one beat on the output channel.
// Output channel (out_valid / out_stall): region_number is the 1-based number
// of the last polygon in use that contains the point, 0 when none does.
// cfg_we / cfg_wdata set the number of polygons checked; write it while idle.
// A vertex write yields no beat. A test point streams the vertex store
// through a row of cells (difference, multiply, parity) at one edge per
// cycle; the single vertex store read port sets this rate.
// A finished beat sits in the output register while vertex writes go on; the
// next test point waits for it to be taken before it completes.
// Reset clears vertex counts, the polygon count and the output; vertex data
// is not cleared and holds whatever was written last.
`default_nettype none
module point_in_polygon_classifier_core
	import pip_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_POLYGONS = DEF_MAX_POLYGONS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic operation,
	input  wire logic [2:0] polygon_slot,
	input  wire logic [5:0] vertex_slot,
	input  wire logic last_vertex,
	input  wire logic [COORD_W-1:0] coord_x,
	input  wire logic [COORD_W-1:0] coord_y,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [REGION_W-1:0] region_number,
	input  wire logic cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);
	localparam int DEPTH = MAX_POLYGONS * MAX_VERTICES;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int PIW = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
	localparam int UW = PIW + 1;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_PRIME  = 5'b00010,
		S_EDGE   = 5'b00100,
		S_FINISH = 5'b01000,
		S_DRAIN  = 5'b10000
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0] used_cfg_q;
	logic [UW-1:0] used_q, poly_q;
	logic [VW-1:0] vidx_q;
	logic [CW-1:0] vcount_q [MAX_POLYGONS];
	logic [CW-1:0] cur_n;
	logic [COORD_W-1:0] tx_q, ty_q;
	logic [2*COORD_W-1:0] vmem [DEPTH];
	logic [2*COORD_W-1:0] rd_s1;
	pip_tag_t tag_nxt, tag_s1;
	pip_diff_t diff_s2;
	pip_prod_t prod_s3;
	logic [AW-1:0] raddr, waddr, base;
	logic accept, wr_en, res_valid;
	logic [REGION_W-1:0] res_region;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign wr_en = accept && (operation == OP_WRITE)
		&& (int'(polygon_slot) < MAX_POLYGONS) && (int'(vertex_slot) < MAX_VERTICES);
	assign waddr = AW'(int'(polygon_slot) * MAX_VERTICES + int'(vertex_slot));
	assign cur_n = vcount_q[poly_q[PIW-1:0]];
	assign base = AW'(int'(poly_q[PIW-1:0]) * MAX_VERTICES);

	always_comb begin
		tag_nxt = '0;
		tag_nxt.poly = POLY_IDX_W'(poly_q);
		raddr = base;
		case (state_q)
			S_PRIME: begin
				if (poly_q != used_q && cur_n != '0) begin
					tag_nxt.prime = 1'b1;
					raddr = base + AW'(cur_n - CW'(1));
				end
			end
			S_EDGE: begin
				tag_nxt.edge_v = 1'b1;
				tag_nxt.last = (CW'(vidx_q) + CW'(1)) == cur_n;
				raddr = base + AW'(vidx_q);
			end
			S_FINISH: begin
				tag_nxt.done = !out_valid;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vmem[waddr] <= {coord_x, coord_y};
		end
		rd_s1 <= vmem[raddr];
	end

	always_ff @(posedge clk) begin
		if (accept && operation == OP_TEST) begin
			tx_q <= coord_x;
			ty_q <= coord_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_cfg_q <= '0;
			used_q <= '0;
			poly_q <= '0;
			vidx_q <= '0;
			tag_s1 <= '0;
			out_valid <= 1'b0;
			region_number <= '0;
			for (int k = 0; k < MAX_POLYGONS; k++) begin
				vcount_q[k] <= '0;
			end
		end else begin
			tag_s1 <= tag_nxt;
			if (cfg_we) begin
				used_cfg_q <= cfg_wdata;
			end
			if (wr_en && last_vertex) begin
				vcount_q[PIW'(polygon_slot)] <= CW'(vertex_slot) + CW'(1);
			end
			if (res_valid) begin
				out_valid <= 1'b1;
				region_number <= res_region;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_TEST) begin
						poly_q <= '0;
						used_q <= (int'(used_cfg_q) > MAX_POLYGONS) ? UW'(MAX_POLYGONS)
							: UW'(used_cfg_q);
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					if (poly_q == used_q) begin
						state_q <= S_FINISH;
					end else if (cur_n == '0) begin
						poly_q <= poly_q + UW'(1);
					end else begin
						vidx_q <= '0;
						state_q <= S_EDGE;
					end
				end
				S_EDGE: begin
					if ((CW'(vidx_q) + CW'(1)) == cur_n) begin
						poly_q <= poly_q + UW'(1);
						state_q <= S_PRIME;
					end else begin
						vidx_q <= vidx_q + VW'(1);
					end
				end
				S_FINISH: begin
					// wait for the output register to empty before the final beat
					if (!out_valid) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (res_valid) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	pip_edge_prep u_prep (
		.clk(clk),
		.arst_n(arst_n),
		.tag_s1(tag_s1),
		.vx_s1(rd_s1[2*COORD_W-1:COORD_W]),
		.vy_s1(rd_s1[COORD_W-1:0]),
		.tx(tx_q),
		.ty(ty_q),
		.diff_s2(diff_s2)
	);

	pip_edge_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.diff_s2(diff_s2),
		.prod_s3(prod_s3)
	);

	pip_parity u_parity (
		.clk(clk),
		.arst_n(arst_n),
		.prod_s3(prod_s3),
		.res_valid(res_valid),
		.res_region(res_region)
	);

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_valid) else $error("result overwrites pending beat");
	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == OP_TEST) |=> state_q == S_PRIME)
		else $error("test point did not start walk");
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> state_q == S_DRAIN) else $error("stray result beat");
`endif
endmodule
`default_nettype wire
